FILE: rtl/cdb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared types, codes and default sizes of the circular deque buffer.
// ----------------------------------------------------------------------------
package cdb_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

FILE: rtl/cdb_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_in_if
// Request channel: one deque operation per transaction.
// ----------------------------------------------------------------------------
interface cdb_in_if;
  logic                              valid;
  logic                              ready;
  logic [cdb_pkg::OP_W-1:0]          op;
  logic [cdb_pkg::VALUE_W-1:0]       value;
  logic signed [cdb_pkg::POS_W-1:0]  position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

FILE: rtl/cdb_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_out_if
// Response channel: data, status and element count of one operation.
// ----------------------------------------------------------------------------
interface cdb_out_if;
  logic                           valid;
  logic                           ready;
  logic [cdb_pkg::DATA_W-1:0]     data;
  logic [cdb_pkg::STATUS_W-1:0]   status;
  logic [cdb_pkg::COUNT_W-1:0]    count;

  modport source (output valid, output data, output status, output count, input ready);
  modport sink   (input valid, input data, input status, input count, output ready);
endinterface

FILE: rtl/cdb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_ctrl
// Sequencer: accept a request, execute it, then hold the response until taken.
// ----------------------------------------------------------------------------
module cdb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cdb_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_SEND = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_SEND);
  assign cmd.load  = req_valid && req_ready;
  assign cmd.exec  = (state == S_CALC);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_CALC;
      end
      S_CALC: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (rsp_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/cdb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdb_datapath
// Entry store, head pointer and fill count, with index resolution and wrap.
// ----------------------------------------------------------------------------
module cdb_datapath #(
  parameter int DEPTH      = cdb_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdb_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cdb_pkg::cmd_t                     cmd,
  input  logic [cdb_pkg::OP_W-1:0]          op,
  input  logic [cdb_pkg::VALUE_W-1:0]       value,
  input  logic signed [cdb_pkg::POS_W-1:0]  position,
  output logic [cdb_pkg::DATA_W-1:0]        data,
  output logic [cdb_pkg::STATUS_W-1:0]      status,
  output logic [cdb_pkg::COUNT_W-1:0]       count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = CNT_W + cdb_pkg::POS_W + 1;

  logic [DATA_WIDTH-1:0]         mem [DEPTH];
  logic [DATA_WIDTH-1:0]         rd_q;

  logic [cdb_pkg::OP_W-1:0]      op_q;
  logic [cdb_pkg::VALUE_W-1:0]   value_q;
  logic [cdb_pkg::POS_W-1:0]     pos_q;

  logic [PTR_W-1:0]              head;
  logic [PTR_W-1:0]              head_next;
  logic [CNT_W-1:0]              fill;
  logic [CNT_W-1:0]              fill_next;
  logic [cdb_pkg::STATUS_W-1:0]  status_q;
  cdb_pkg::status_t              status_next;
  logic                          data_en_q;
  logic                          data_en_next;

  logic                          full;
  logic                          empty;
  logic [CNT_W-1:0]              fill_m1;
  logic [cdb_pkg::POS_W-1:0]     neg_amt;
  logic [EXT_W-1:0]              fill_ext;
  logic [EXT_W-1:0]              neg_ext;
  logic [EXT_W-1:0]              pos_ext;
  logic [EXT_W-1:0]              idx_ext;
  logic                          idx_ok;
  logic [PTR_W-1:0]              logical;
  logic [PTR_W:0]                slot_sum;
  logic [PTR_W-1:0]              slot;
  logic [PTR_W-1:0]              head_dec;
  logic [PTR_W-1:0]              head_inc;
  logic [PTR_W-1:0]              addr;
  logic                          wr_en;
  logic                          rd_en;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign fill_m1 = fill - 1'b1;

  assign neg_amt  = ~pos_q + 1'b1;
  assign fill_ext = EXT_W'(fill);
  assign neg_ext  = EXT_W'(neg_amt);
  assign pos_ext  = EXT_W'(pos_q);
  assign idx_ok   = pos_q[cdb_pkg::POS_W-1] ? (fill_ext >= neg_ext) : (pos_ext < fill_ext);
  assign idx_ext  = pos_q[cdb_pkg::POS_W-1] ? (fill_ext - neg_ext) : pos_ext;

  always_comb begin
    case (op_q)
      cdb_pkg::OP_PUSH_BACK: logical = fill[PTR_W-1:0];
      cdb_pkg::OP_POP_BACK:  logical = fill_m1[PTR_W-1:0];
      default:               logical = idx_ext[PTR_W-1:0];
    endcase
  end

  assign slot_sum = {1'b0, head} + {1'b0, logical};
  assign slot     = (slot_sum >= (PTR_W + 1)'(DEPTH)) ?
                    PTR_W'(slot_sum - (PTR_W + 1)'(DEPTH)) : slot_sum[PTR_W-1:0];
  assign head_dec = (head == '0) ? PTR_W'(DEPTH - 1) : head - 1'b1;
  assign head_inc = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;

  always_comb begin
    head_next    = head;
    fill_next    = fill;
    status_next  = cdb_pkg::ST_OK;
    data_en_next = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    addr         = slot;
    case (op_q)
      cdb_pkg::OP_PUSH_FRONT: begin
        addr = head_dec;
        if (full) begin
          status_next = cdb_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          head_next = head_dec;
          fill_next = fill + 1'b1;
        end
      end
      cdb_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_next = cdb_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          fill_next = fill + 1'b1;
        end
      end
      cdb_pkg::OP_POP_FRONT: begin
        addr = head;
        if (empty) begin
          status_next = cdb_pkg::ST_RANGE;
        end else begin
          rd_en        = 1'b1;
          data_en_next = 1'b1;
          head_next    = head_inc;
          fill_next    = fill_m1;
        end
      end
      cdb_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_next = cdb_pkg::ST_RANGE;
        end else begin
          rd_en        = 1'b1;
          data_en_next = 1'b1;
          fill_next    = fill_m1;
        end
      end
      cdb_pkg::OP_READ: begin
        if (idx_ok) begin
          rd_en        = 1'b1;
          data_en_next = 1'b1;
        end else begin
          status_next = cdb_pkg::ST_RANGE;
        end
      end
      cdb_pkg::OP_WRITE: begin
        if (idx_ok) begin
          wr_en = 1'b1;
        end else begin
          status_next = cdb_pkg::ST_RANGE;
        end
      end
      default: begin
        status_next = cdb_pkg::ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op;
      value_q <= value;
      pos_q   <= position;
    end
    if (cmd.exec) begin
      status_q  <= status_next;
      data_en_q <= data_en_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[addr] <= DATA_WIDTH'(value_q);
    end
    if (cmd.exec && rd_en) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  assign data   = data_en_q ? cdb_pkg::DATA_W'(rd_q) : '0;
  assign status = status_q;
  assign count  = cdb_pkg::COUNT_W'(fill);

endmodule

FILE: rtl/circular_deque_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_buffer_top
// Fixed-capacity double-ended ring buffer with indexed read and write.
// ----------------------------------------------------------------------------
// Usage:
//   Each request transaction on req carries op, value and position and asks
//   for one operation: push or pop at either end, or read or write the
//   element at a logical index, where a negative index counts from the back.
//   Each request yields exactly one response transaction on rsp with data,
//   status (ok, out of range, full) and the element count afterwards.
//   The response becomes valid once the request has been registered and then
//   executed; the result passes through the registered read port of the entry
//   store and the response register, which holds until the receiver takes it.
//   Items are handled one at a time: no new request is accepted until the
//   response has been taken.
//   While the receiver stalls, the response is held steady and no new request
//   is accepted. Reset empties the buffer (head pointer and count cleared);
//   stored words are left as they are and are never read before written.
// ----------------------------------------------------------------------------
module circular_deque_buffer_top #(
  parameter int DEPTH      = cdb_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdb_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cdb_in_if.sink     req,
  cdb_out_if.source  rsp
);

  cdb_pkg::cmd_t cmd;

  cdb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  cdb_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .op       (req.op),
    .value    (req.value),
    .position (req.position),
    .data     (rsp.data),
    .status   (rsp.status),
    .count    (rsp.count)
  );

endmodule

FILE: dv/circular_deque_buffer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_buffer_top_tb
// Self-checking bench for the double-ended ring buffer. A scoreboard class
// keeps its own copy of the slots, head and element count, predicts the
// response to every accepted request transaction and compares each accepted
// response field by field. Directed operations cover the empty, full and
// out-of-range cases, then random sequences that grow, shrink and index the
// buffer run under several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module circular_deque_buffer_top_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [cdb_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [cdb_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  class deque_scoreboard;
    typedef struct {
      logic [cdb_pkg::DATA_W-1:0]   data;
      logic [cdb_pkg::STATUS_W-1:0] status;
      logic [cdb_pkg::COUNT_W-1:0]  count;
    } reply_t;

    logic [cdb_pkg::VALUE_W-1:0] slots [cdb_pkg::DEPTH_DEF];
    int                          head;
    int                          fill;
    int                          mismatches;
    reply_t                      replies_due [$];

    function new();
      head       = 0;
      fill       = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void note_request(logic [cdb_pkg::OP_W-1:0] op,
                               logic [cdb_pkg::VALUE_W-1:0] value,
                               logic signed [cdb_pkg::POS_W-1:0] position);
      reply_t r;
      int     idx;
      r.data   = '0;
      r.status = cdb_pkg::ST_OK;
      idx      = int'(position);
      if (idx < 0) idx += fill;
      case (op)
        cdb_pkg::OP_PUSH_FRONT: begin
          if (fill >= cdb_pkg::DEPTH_DEF) begin
            r.status = cdb_pkg::ST_FULL;
          end else begin
            head = (head + cdb_pkg::DEPTH_DEF - 1) % cdb_pkg::DEPTH_DEF;
            slots[head] = value;
            fill++;
          end
        end
        cdb_pkg::OP_PUSH_BACK: begin
          if (fill >= cdb_pkg::DEPTH_DEF) begin
            r.status = cdb_pkg::ST_FULL;
          end else begin
            slots[(head + fill) % cdb_pkg::DEPTH_DEF] = value;
            fill++;
          end
        end
        cdb_pkg::OP_POP_FRONT: begin
          if (fill == 0) begin
            r.status = cdb_pkg::ST_RANGE;
          end else begin
            r.data = slots[head];
            head = (head + 1) % cdb_pkg::DEPTH_DEF;
            fill--;
          end
        end
        cdb_pkg::OP_POP_BACK: begin
          if (fill == 0) begin
            r.status = cdb_pkg::ST_RANGE;
          end else begin
            r.data = slots[(head + fill - 1) % cdb_pkg::DEPTH_DEF];
            fill--;
          end
        end
        cdb_pkg::OP_READ: begin
          if (idx < 0 || idx >= fill) r.status = cdb_pkg::ST_RANGE;
          else r.data = slots[(head + idx) % cdb_pkg::DEPTH_DEF];
        end
        cdb_pkg::OP_WRITE: begin
          if (idx < 0 || idx >= fill) r.status = cdb_pkg::ST_RANGE;
          else slots[(head + idx) % cdb_pkg::DEPTH_DEF] = value;
        end
        default: r.status = cdb_pkg::ST_RANGE;
      endcase
      r.count = fill[cdb_pkg::COUNT_W-1:0];
      replies_due.push_back(r);
    endfunction

    task check_response(logic [cdb_pkg::DATA_W-1:0] data,
                        logic [cdb_pkg::STATUS_W-1:0] status,
                        logic [cdb_pkg::COUNT_W-1:0] count);
      reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("response with none outstanding: data %h status %0d count %0d",
                         data, status, count));
        return;
      end
      want = replies_due.pop_front();
      if (data !== want.data)
        report($sformatf("data %h, expected %h", data, want.data));
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
      if (count !== want.count)
        report($sformatf("count %0d, expected %0d", count, want.count));
    endtask
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_cycles    = 0;
  int   cycles         = 0;

  deque_scoreboard sb = new();

  cdb_in_if  req_ch ();
  cdb_out_if rsp_ch ();

  circular_deque_buffer_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response(rsp_ch.data, rsp_ch.status, rsp_ch.count);
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.op, req_ch.value, req_ch.position);
    end
  end

  // The long hold-off is requested by the stimulus and timed here.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task send_item(input logic [cdb_pkg::OP_W-1:0] op,
                 input logic [cdb_pkg::VALUE_W-1:0] value,
                 input int position);
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.value    <= value;
    req_ch.position <= cdb_pkg::POS_W'(position);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid    <= 1'b0;
      req_ch.op       <= cdb_pkg::OP_W'($urandom_range(7));
      req_ch.value    <= $urandom;
      req_ch.position <= cdb_pkg::POS_W'($urandom_range(31));
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task run_random(input int n);
    int                          mode;
    int                          roll;
    int                          idx;
    int                          push_pct;
    int                          pop_pct;
    logic [cdb_pkg::OP_W-1:0]    op;
    int                          pos;
    mode = 2;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) mode = $urandom_range(2);
      push_pct = (mode == 0) ? 60 : (mode == 1) ? 10 : 25;
      pop_pct  = (mode == 0) ? 10 : (mode == 1) ? 60 : 25;
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        op = roll[0] ? cdb_pkg::OP_PUSH_BACK : cdb_pkg::OP_PUSH_FRONT;
      end else if (roll < push_pct + pop_pct) begin
        op = roll[0] ? cdb_pkg::OP_POP_BACK : cdb_pkg::OP_POP_FRONT;
      end else if (roll < 97) begin
        op = roll[0] ? cdb_pkg::OP_WRITE : cdb_pkg::OP_READ;
      end else begin
        op = roll[0] ? OP_SPARE_HI : OP_SPARE_LO;
      end
      if (sb.fill > 0 && $urandom_range(9) < 8) begin
        idx = $urandom_range(sb.fill - 1);
        if ($urandom_range(1) == 1) idx -= sb.fill;
        pos = idx;
      end else begin
        pos = int'($urandom_range(31));
      end
      send_item(op, $urandom, pos);
    end
  endtask

  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.op       <= cdb_pkg::OP_PUSH_FRONT;
    req_ch.value    <= '0;
    req_ch.position <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_item(cdb_pkg::OP_POP_FRONT, 0, 0);
    send_item(cdb_pkg::OP_POP_BACK, 0, 0);
    send_item(cdb_pkg::OP_READ, 0, 0);
    send_item(cdb_pkg::OP_WRITE, 32'h1111_2222, -1);
    send_item(OP_SPARE_LO, 32'hFFFF_FFFF, 0);
    send_item(OP_SPARE_HI, 0, -1);
    send_item(cdb_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 0);
    send_item(cdb_pkg::OP_PUSH_BACK, 32'h0000_0000, 0);
    send_item(cdb_pkg::OP_PUSH_BACK, 32'hA5A5_A5A5, 0);
    send_item(cdb_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A, 0);
    send_item(cdb_pkg::OP_READ, 0, 0);
    send_item(cdb_pkg::OP_READ, 0, -1);
    send_item(cdb_pkg::OP_READ, 0, 3);
    send_item(cdb_pkg::OP_READ, 0, 4);
    send_item(cdb_pkg::OP_READ, 0, -4);
    send_item(cdb_pkg::OP_READ, 0, -5);
    send_item(cdb_pkg::OP_READ, 0, -16);
    send_item(cdb_pkg::OP_READ, 0, 15);
    send_item(cdb_pkg::OP_WRITE, 32'h1234_5678, 2);
    send_item(cdb_pkg::OP_WRITE, 32'hDEAD_BEEF, -3);
    send_item(cdb_pkg::OP_READ, 0, 2);
    send_item(cdb_pkg::OP_POP_FRONT, 0, 0);
    send_item(cdb_pkg::OP_POP_BACK, 0, 0);
    drain();

    // Responses are first held off, then 24 pushes follow, more than the buffer holds, so it fills.
    hold_cycles = 300;
    for (int i = 0; i < 24; i++)
      send_item(($urandom_range(1) == 1) ? cdb_pkg::OP_PUSH_BACK : cdb_pkg::OP_PUSH_FRONT,
                $urandom, 0);
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;
    run_random(300);
    drain();
    send_idle_pct = 79; recv_stall_pct = 0;
    run_random(300);
    drain();
    send_idle_pct = 0;  recv_stall_pct = 79;
    run_random(300);
    drain();
    send_idle_pct = 10; recv_stall_pct = 10;
    run_random(300);
    drain();

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cdb_pkg.sv
rtl/cdb_in_if.sv
rtl/cdb_out_if.sv
rtl/cdb_ctrl.sv
rtl/cdb_datapath.sv
rtl/circular_deque_buffer_top.sv
dv/circular_deque_buffer_top_tb.sv
